/* sv/lcts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcts_pkg: shared types and constants of the oscillator tuning sweep
// Field widths, register indexes, reset values and the structs that travel
// between the sweep blocks.
// ----------------------------------------------------------------------------
package lcts_pkg;

   localparam int NUM_SETTINGS_DEF = 16;
   localparam int COUNT_WIDTH_DEF  = 16;

   localparam int SETTING_W  = 4;
   localparam int FREQ_W     = 28;
   localparam int HZ_W       = 24;
   localparam int TICKS_W    = 24;
   localparam int SCALE_W    = 13;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;

   localparam logic [HZ_W-1:0]    TARGET_RST    = 24'd500000;
   localparam logic [HZ_W-1:0]    TOLERANCE_RST = 24'd17500;
   localparam logic [TICKS_W-1:0] WINDOW_RST    = 24'd250;
   localparam logic [SCALE_W-1:0] SCALE_RST     = 13'd512;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET    = 2'd0,
      CSR_TOLERANCE = 2'd1,
      CSR_WINDOW    = 2'd2,
      CSR_SCALE     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [HZ_W-1:0]    target_frequency;
      logic [HZ_W-1:0]    tolerance;
      logic [TICKS_W-1:0] window_ticks;
      logic [SCALE_W-1:0] count_scale;
   } cfg_type;

   typedef struct packed {
      logic start_req;
      logic tick;
      logic edge_req;
   } item_type;

   typedef struct packed {
      logic [SETTING_W-1:0] tune_setting;
      logic                 oscillator_enable;
      logic                 done_res;
      logic                 found;
      logic [SETTING_W-1:0] best_setting;
      logic [FREQ_W-1:0]    best_frequency;
   } result_type;

endpackage

/* sv/lcts_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcts_if: item channels of the oscillator tuning sweep
// Valid/ready channels for the sampled input item and the status result item.
// ----------------------------------------------------------------------------
interface lcts_req_if;
   logic valid;
   logic ready;
   logic start_req;
   logic tick;
   logic edge_req;

   modport source (output valid, start_req, tick, edge_req, input ready);
   modport sink   (input valid, start_req, tick, edge_req, output ready);
endinterface

interface lcts_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [lcts_pkg::SETTING_W-1:0]     tune_setting;
   logic                               oscillator_enable;
   logic                               done_res;
   logic                               found;
   logic [lcts_pkg::SETTING_W-1:0]     best_setting;
   logic [lcts_pkg::FREQ_W-1:0]        best_frequency;

   modport source (output valid, tune_setting, oscillator_enable, done_res, found,
                   best_setting, best_frequency, input ready);
   modport sink   (input valid, tune_setting, oscillator_enable, done_res, found,
                   best_setting, best_frequency, output ready);
endinterface

/* sv/lcts_freq_err.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcts_freq_err: frequency and error of one gate window
// Scales the edge count into hertz with saturation and forms the absolute
// difference from the target frequency.
// ----------------------------------------------------------------------------
module lcts_freq_err #(
   parameter int COUNT_WIDTH = lcts_pkg::COUNT_WIDTH_DEF
) (
   input  logic [COUNT_WIDTH-1:0]          edge_count,
   input  logic [lcts_pkg::SCALE_W-1:0]    count_scale,
   input  logic [lcts_pkg::HZ_W-1:0]       target_frequency,
   output logic [lcts_pkg::FREQ_W-1:0]     frequency,
   output logic [lcts_pkg::FREQ_W-1:0]     abs_error
);

   localparam int PROD_W = COUNT_WIDTH + lcts_pkg::SCALE_W;
   localparam int EXT_W  = (PROD_W > lcts_pkg::FREQ_W) ? PROD_W : lcts_pkg::FREQ_W + 1;

   logic [EXT_W-1:0]              product;
   logic [lcts_pkg::FREQ_W-1:0]   target_ext;

   assign product    = EXT_W'(edge_count) * EXT_W'(count_scale);
   assign target_ext = lcts_pkg::FREQ_W'(target_frequency);

   // Anything above the result width saturates to all ones.
   assign frequency = (product[EXT_W-1:lcts_pkg::FREQ_W] != '0) ? '1
                                                             : product[lcts_pkg::FREQ_W-1:0];

   assign abs_error = (frequency >= target_ext) ? frequency - target_ext
                                                : target_ext - frequency;

endmodule

/* sv/lcts_sweep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcts_sweep: sweep state and per-item update
// Holds the sweep state, applies one item per step and presents the status
// that results from it.
// ----------------------------------------------------------------------------
module lcts_sweep #(
   parameter int NUM_SETTINGS = lcts_pkg::NUM_SETTINGS_DEF,
   parameter int COUNT_WIDTH  = lcts_pkg::COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  lcts_pkg::item_type    item,
   input  lcts_pkg::cfg_type     cfg,
   output lcts_pkg::result_type  result
);

   localparam logic [lcts_pkg::SETTING_W-1:0] LAST_SETTING =
      lcts_pkg::SETTING_W'(NUM_SETTINGS - 1);

   logic                              running_ff, running_in;
   logic [lcts_pkg::SETTING_W-1:0]    setting_ff, setting_in;
   logic [COUNT_WIDTH-1:0]            count_ff, count_in;
   logic [lcts_pkg::TICKS_W-1:0]      window_ff, window_in;
   logic [lcts_pkg::FREQ_W-1:0]       best_err_ff, best_err_in;
   logic [lcts_pkg::SETTING_W-1:0]    best_idx_ff, best_idx_in;
   logic [lcts_pkg::FREQ_W-1:0]       best_hz_ff, best_hz_in;
   logic                              within_ff, within_in;

   logic [COUNT_WIDTH-1:0]            count_next;
   logic [lcts_pkg::TICKS_W-1:0]      window_next;
   logic [lcts_pkg::FREQ_W-1:0]       frequency;
   logic [lcts_pkg::FREQ_W-1:0]       abs_error;
   logic                              done;

   // The edge of the closing item is counted into the window.
   assign count_next  = (item.edge_req && (count_ff != '1)) ? count_ff + 1'b1 : count_ff;
   assign window_next = window_ff + 1'b1;

   lcts_freq_err #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_freq_err (
      .edge_count       (count_next),
      .count_scale      (cfg.count_scale),
      .target_frequency (cfg.target_frequency),
      .frequency        (frequency),
      .abs_error        (abs_error)
   );

   always_comb begin
      running_in  = running_ff;
      setting_in  = setting_ff;
      count_in    = count_ff;
      window_in   = window_ff;
      best_err_in = best_err_ff;
      best_idx_in = best_idx_ff;
      best_hz_in  = best_hz_ff;
      within_in   = within_ff;
      done        = 1'b0;
      if (item.start_req) begin
         running_in  = 1'b1;
         setting_in  = '0;
         count_in    = '0;
         window_in   = '0;
         best_err_in = '0;
         best_idx_in = '0;
         best_hz_in  = '0;
         within_in   = 1'b0;
      end else if (running_ff) begin
         count_in = count_next;
         if (item.tick) begin
            window_in = window_next;
            // A wrapped counter also closes the window.
            if ((window_next == '0) || (window_next >= cfg.window_ticks)) begin
               // The first setting is always taken; ties keep the earlier one.
               if ((setting_ff == '0) || (abs_error < best_err_ff)) begin
                  best_err_in = abs_error;
                  best_idx_in = setting_ff;
                  best_hz_in  = frequency;
               end
               within_in = best_err_in < lcts_pkg::FREQ_W'(cfg.tolerance);
               count_in  = '0;
               window_in = '0;
               if (setting_ff >= LAST_SETTING) begin
                  running_in = 1'b0;
                  done       = 1'b1;
               end else begin
                  setting_in = setting_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         setting_ff  <= '0;
         count_ff    <= '0;
         window_ff   <= '0;
         best_err_ff <= '0;
         best_idx_ff <= '0;
         best_hz_ff  <= '0;
         within_ff   <= 1'b0;
      end else if (step) begin
         running_ff  <= running_in;
         setting_ff  <= setting_in;
         count_ff    <= count_in;
         window_ff   <= window_in;
         best_err_ff <= best_err_in;
         best_idx_ff <= best_idx_in;
         best_hz_ff  <= best_hz_in;
         within_ff   <= within_in;
      end
   end

   assign result.tune_setting      = setting_in;
   assign result.oscillator_enable = running_in;
   assign result.done_res          = done;
   assign result.found             = within_in;
   assign result.best_setting      = best_idx_in;
   assign result.best_frequency    = best_hz_in;

   a_setting_range: assert property (@(posedge clock) disable iff (reset)
      setting_ff <= LAST_SETTING)
      else $error("sweep setting beyond the last capacitor setting");

   a_best_not_ahead: assert property (@(posedge clock) disable iff (reset)
      best_idx_ff <= setting_ff)
      else $error("best setting lies ahead of the setting being measured");

   a_idle_count_clear: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (count_ff == '0 && window_ff == '0))
      else $error("counters not cleared while no sweep runs");

   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      (step && done) |=> (!running_ff && setting_ff == LAST_SETTING))
      else $error("sweep did not stop on the last setting");

endmodule

/* sv/lc_antenna_tuning_sweep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc_antenna_tuning_sweep: automatic oscillator tuning by capacitor sweep
// Sweeps the capacitor settings, measures the oscillator in a gate window per
// setting and reports the setting closest to the target frequency.
// ----------------------------------------------------------------------------
// Each item carries one clock sample of the start request, the time base tick
// and the divided oscillator edge, and every accepted item yields exactly one
// result item with the setting being driven, the oscillator enable and the
// sweep outcome. The block takes one item per cycle while results are taken.
// The item is held in an input register, the sweep state is updated from it
// in a single pass whose longest path is the edge count times the count
// scale followed by the error subtract and compare, and the status lands in
// a result register. A held result stops the input side only once both
// registers are full. Configuration registers are written through the csr
// port; the user must do so only while no item is in flight, which the block
// does not enforce. A write takes effect for the next item. A start request
// restarts the sweep at setting zero and ignores the tick and edge of that
// same item. Found is true when the best error so far is strictly below the
// tolerance and is final on the item that carries done.
// ----------------------------------------------------------------------------
module lc_antenna_tuning_sweep #(
   parameter int NUM_SETTINGS = lcts_pkg::NUM_SETTINGS_DEF,
   parameter int COUNT_WIDTH  = lcts_pkg::COUNT_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   lcts_req_if.sink                           req_chan,
   lcts_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [lcts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lcts_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // Configuration registers.
   lcts_pkg::cfg_type    cfg_ff;

   // Input register: one item waiting to be applied to the sweep state.
   logic                 in_valid_ff, in_valid_in;
   lcts_pkg::item_type   in_item_ff;

   // Result register.
   logic                 out_valid_ff, out_valid_in;
   lcts_pkg::result_type out_ff;

   lcts_pkg::result_type step_result;
   logic                 req_accept;
   logic                 out_free;
   logic                 advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_frequency <= lcts_pkg::TARGET_RST;
         cfg_ff.tolerance        <= lcts_pkg::TOLERANCE_RST;
         cfg_ff.window_ticks     <= lcts_pkg::WINDOW_RST;
         cfg_ff.count_scale      <= lcts_pkg::SCALE_RST;
      end else if (csr_we) begin
         unique case (lcts_pkg::csr_index_type'(csr_index))
            lcts_pkg::CSR_TARGET: begin
               cfg_ff.target_frequency <= csr_wdata[lcts_pkg::HZ_W-1:0];
            end
            lcts_pkg::CSR_TOLERANCE: begin
               cfg_ff.tolerance <= csr_wdata[lcts_pkg::HZ_W-1:0];
            end
            lcts_pkg::CSR_WINDOW: begin
               cfg_ff.window_ticks <= csr_wdata[lcts_pkg::TICKS_W-1:0];
            end
            lcts_pkg::CSR_SCALE: begin
               cfg_ff.count_scale <= csr_wdata[lcts_pkg::SCALE_W-1:0];
            end
         endcase
      end
   end

   // The held item moves on whenever the result register is empty or drains
   // in this cycle; the input register refills in the same cycle.
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.start_req <= req_chan.start_req;
         in_item_ff.tick      <= req_chan.tick;
         in_item_ff.edge_req  <= req_chan.edge_req;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   lcts_sweep #(
      .NUM_SETTINGS (NUM_SETTINGS),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_sweep (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.tune_setting      = out_ff.tune_setting;
   assign rsp_chan.oscillator_enable = out_ff.oscillator_enable;
   assign rsp_chan.done_res          = out_ff.done_res;
   assign rsp_chan.found             = out_ff.found;
   assign rsp_chan.best_setting      = out_ff.best_setting;
   assign rsp_chan.best_frequency    = out_ff.best_frequency;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.done_res) |-> !out_ff.oscillator_enable)
      else $error("done reported while the oscillator is still enabled");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |-> !req_chan.ready)
      else $error("input item accepted over a stalled held item");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("applied item produced no result");

endmodule
